>>> rtl/twd_pkg.sv
// Shared types and constants of the twiddle PID gain tuner.
package twd_pkg;

   localparam int NUM_GAINS = 3;
   localparam int ERR_BITS = 16;
   localparam int GAIN_BITS = 32;
   localparam int STEP_BITS = 32;
   localparam int SUM_BITS = 48;
   localparam int QUOT_BITS = 29;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_TOLERANCE = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SETTLE_STEPS = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EVAL_STEPS = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_KP = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_KI = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_KD = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_STEP_PD = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_START_STEP_I = 3'd7;

   // Gain selectors.
   localparam logic [1:0] GAIN_P = 2'd0;
   localparam logic [1:0] GAIN_I = 2'd1;
   localparam logic [1:0] GAIN_D = 2'd2;

   // Register values after reset.
   localparam logic [30:0] TOLERANCE_RESET = 31'd3355443;
   localparam logic [9:0] SETTLE_RESET = 10'd100;
   localparam logic [9:0] EVAL_RESET = 10'd700;
   localparam logic [31:0] START_GAIN_RESET = 32'd0;
   localparam logic [30:0] START_STEP_PD_RESET = 31'd167772;
   localparam logic [30:0] START_STEP_I_RESET = 31'd168;

   // ceil(2^35 / 10): x * RECIP_10 >> 35 is x / 10 for every 32-bit x.
   localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

   typedef struct packed {
      logic signed [ERR_BITS-1:0] cross_error;
   } twd_req_type;

   typedef struct packed {
      logic signed [GAIN_BITS-1:0] gain_p;
      logic signed [GAIN_BITS-1:0] gain_i;
      logic signed [GAIN_BITS-1:0] gain_d;
      logic [1:0] gain_index;
      logic tuning_done;
   } twd_rsp_type;

   // Precomputed step-size updates for the gain under tuning.
   typedef struct packed {
      logic [STEP_BITS-1:0] grow;
      logic [STEP_BITS-1:0] shrink;
      logic grow_done;
      logic shrink_done;
   } twd_scale_type;

endpackage

>>> rtl/twd_chan_if.sv
// Valid/ready channel interfaces for error samples and gain results.
interface twd_req_if import twd_pkg::*; ();
   logic valid;
   logic ready;
   twd_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface twd_rsp_if import twd_pkg::*; ();
   logic valid;
   logic ready;
   twd_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/twd_step_scale.sv
// Two-stage unit that precomputes dp*1.1, dp*0.9 and their stop checks.
module twd_step_scale import twd_pkg::*; (
   input logic clock,
   input logic [STEP_BITS-1:0] step_cur,
   input logic [STEP_BITS+1:0] step_others,
   input logic [30:0] tolerance,
   output twd_scale_type scale
);

   logic [2*STEP_BITS-1:0] product;
   logic [QUOT_BITS-1:0] quot_ff;
   logic [QUOT_BITS-1:0] quot_in;
   logic [STEP_BITS-1:0] dp_ff;
   logic [STEP_BITS+2:0] slack_ff;
   logic [STEP_BITS+2:0] slack_in;
   logic [STEP_BITS-1:0] ten_quot;
   logic [STEP_BITS:0] grow_sum;
   logic exact;
   twd_scale_type scale_ff;
   twd_scale_type scale_in;

   // Stage one: quotient by reciprocal multiply, room left under the tolerance.
   always_comb begin
      product = step_cur * RECIP_10;
      quot_in = product[2*STEP_BITS-1:35];
      slack_in = {4'b0, tolerance} - {1'b0, step_others};
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      dp_ff <= step_cur;
      slack_ff <= slack_in;
   end

   // Stage two: dp + dp/10 saturated, and dp - ceil(dp/10).
   always_comb begin
      ten_quot = {quot_ff, 3'b000} + {2'b00, quot_ff, 1'b0};
      exact = (ten_quot == dp_ff);
      grow_sum = {1'b0, dp_ff} + {4'b0, quot_ff};
      scale_in.grow = grow_sum[STEP_BITS] ? '1 : grow_sum[STEP_BITS-1:0];
      scale_in.shrink = dp_ff - {3'b0, quot_ff} - {{(STEP_BITS-1){1'b0}}, !exact};
      scale_in.grow_done = !slack_ff[STEP_BITS+2] &&
                           ({3'b0, scale_in.grow} <= slack_ff);
      scale_in.shrink_done = !slack_ff[STEP_BITS+2] &&
                             ({3'b0, scale_in.shrink} <= slack_ff);
   end

   always_ff @(posedge clock) begin
      scale_ff <= scale_in;
   end

   assign scale = scale_ff;

endmodule

>>> rtl/twiddle_pid_gain_tuner_core.sv
// Top level of the twiddle PID gain tuner: sample windows, decisions and result buffer.
//
//   channel  | dir | handshake          | contents
//   req_chan | in  | valid/ready        | cross_error, signed Q8.8
//   rsp_chan | out | valid/ready        | gain_p/i/d Q8.24, gain_index, tuning_done
//   csr_*    | in  | csr_we, no ready   | csr_index selects register, csr_wdata
//
// One transaction per cycle is accepted while req_chan is ready; each produces one registered result.
// The per-sample state update (square, 48-bit sum, decision) is done in the accept cycle.
// Step-size scaling runs in a two-stage side unit that is settled before any decision uses it.
// Synchronous reset and any register write restart the tuner from the register values.
// A two-entry output buffer keeps req_chan ready while one result waits on a stall.
module twiddle_pid_gain_tuner_core import twd_pkg::*; #(
   parameter int COUNT_BITS = 11
) (
   input logic clock,
   input logic reset,
   twd_req_if.sink req_chan,
   twd_rsp_if.source rsp_chan,
   input logic csr_we,
   input logic [CSR_IDX_BITS-1:0] csr_index,
   input logic [CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int CMP_BITS = (COUNT_BITS > 11) ? COUNT_BITS : 11;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // Configuration registers.
   logic [30:0] tolerance_ff, tolerance_in;
   logic [9:0] settle_ff, settle_in;
   logic [9:0] eval_ff, eval_in;
   logic [31:0] start_kp_ff, start_kp_in;
   logic [31:0] start_ki_ff, start_ki_in;
   logic [31:0] start_kd_ff, start_kd_in;
   logic [30:0] step_pd_ff, step_pd_in;
   logic [30:0] step_i_ff, step_i_in;

   // Values that a restart loads.
   logic restart;
   logic [9:0] ld_settle;
   logic [31:0] ld_kp, ld_ki, ld_kd;
   logic [30:0] ld_step_pd, ld_step_i;

   // Tuner state.
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SUM_BITS-1:0] err_sum_ff, err_sum_in;
   logic [SUM_BITS-1:0] best_ff, best_in;
   logic [STEP_BITS-1:0] step_ff [NUM_GAINS];
   logic [STEP_BITS-1:0] step_in [NUM_GAINS];
   logic signed [GAIN_BITS-1:0] gain_ff [NUM_GAINS];
   logic signed [GAIN_BITS-1:0] gain_in [NUM_GAINS];
   logic [1:0] index_ff, index_in;
   logic tried_ff, tried_in;
   logic apply_ff, apply_in;
   logic first_ff, first_in;

   // Datapath.
   logic accept;
   logic [CMP_BITS-1:0] cnt_ext, settle_ext, limit_ext;
   logic [10:0] limit;
   logic at_max, in_settle, in_eval;
   logic signed [2*ERR_BITS-1:0] sq_signed;
   logic [2*ERR_BITS-1:0] sq;
   logic [SUM_BITS:0] sum_next;
   logic [STEP_BITS+1:0] step_total;
   logic [STEP_BITS+1:0] step_others;
   logic done_now, done_next;
   logic [STEP_BITS-1:0] dp;
   logic signed [GAIN_BITS-1:0] gain_k;
   logic signed [GAIN_BITS+2:0] gain_plus, gain_minus;
   logic signed [GAIN_BITS-1:0] gain_plus_sat, gain_minus_sat;
   logic [1:0] index_next;
   logic gain_wr, step_wr;
   logic signed [GAIN_BITS-1:0] gain_new;
   logic [STEP_BITS-1:0] step_new;
   twd_scale_type scale;
   twd_rsp_type result;

   // Output buffer.
   logic out_valid_ff, skid_valid_ff;
   twd_rsp_type out_ff, skid_ff;
   logic take;

   function automatic logic signed [GAIN_BITS-1:0] sat_gain(
      input logic signed [GAIN_BITS+2:0] value
   );
      logic [3:0] top;
      begin
         top = value[GAIN_BITS+2:GAIN_BITS-1];
         if (top == 4'b0000 || top == 4'b1111) begin
            sat_gain = value[GAIN_BITS-1:0];
         end else if (value[GAIN_BITS+2]) begin
            sat_gain = {1'b1, {(GAIN_BITS-1){1'b0}}};
         end else begin
            sat_gain = {1'b0, {(GAIN_BITS-1){1'b1}}};
         end
      end
   endfunction

   // Configuration writes.
   always_comb begin
      tolerance_in = tolerance_ff;
      settle_in = settle_ff;
      eval_in = eval_ff;
      start_kp_in = start_kp_ff;
      start_ki_in = start_ki_ff;
      start_kd_in = start_kd_ff;
      step_pd_in = step_pd_ff;
      step_i_in = step_i_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TOLERANCE: tolerance_in = csr_wdata[30:0];
            CSR_SETTLE_STEPS: settle_in = csr_wdata[9:0];
            CSR_EVAL_STEPS: eval_in = csr_wdata[9:0];
            CSR_START_KP: start_kp_in = csr_wdata;
            CSR_START_KI: start_ki_in = csr_wdata;
            CSR_START_KD: start_kd_in = csr_wdata;
            CSR_START_STEP_PD: step_pd_in = csr_wdata[30:0];
            CSR_START_STEP_I: step_i_in = csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= TOLERANCE_RESET;
         settle_ff <= SETTLE_RESET;
         eval_ff <= EVAL_RESET;
         start_kp_ff <= START_GAIN_RESET;
         start_ki_ff <= START_GAIN_RESET;
         start_kd_ff <= START_GAIN_RESET;
         step_pd_ff <= START_STEP_PD_RESET;
         step_i_ff <= START_STEP_I_RESET;
      end else begin
         tolerance_ff <= tolerance_in;
         settle_ff <= settle_in;
         eval_ff <= eval_in;
         start_kp_ff <= start_kp_in;
         start_ki_ff <= start_ki_in;
         start_kd_ff <= start_kd_in;
         step_pd_ff <= step_pd_in;
         step_i_ff <= step_i_in;
      end
   end

   // A restart sees the register values as they are after the write.
   always_comb begin
      restart = reset || csr_we;
      ld_settle = reset ? SETTLE_RESET : settle_in;
      ld_kp = reset ? START_GAIN_RESET : start_kp_in;
      ld_ki = reset ? START_GAIN_RESET : start_ki_in;
      ld_kd = reset ? START_GAIN_RESET : start_kd_in;
      ld_step_pd = reset ? START_STEP_PD_RESET : step_pd_in;
      ld_step_i = reset ? START_STEP_I_RESET : step_i_in;
   end

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !skid_valid_ff;

   // Window position of this sample.
   always_comb begin
      limit = {1'b0, settle_ff} + {1'b0, eval_ff};
      cnt_ext = CMP_BITS'(count_ff);
      settle_ext = CMP_BITS'(settle_ff);
      limit_ext = CMP_BITS'(limit);
      at_max = (count_ff == CNT_MAX);
      in_settle = (cnt_ext <= settle_ext) && !at_max;
      in_eval = !in_settle && (cnt_ext <= limit_ext) && !at_max;
   end

   always_comb begin
      sq_signed = req_chan.payload.cross_error * req_chan.payload.cross_error;
      sq = $unsigned(sq_signed);
      sum_next = {1'b0, err_sum_ff} + {{(SUM_BITS+1-2*ERR_BITS){1'b0}}, sq};
   end

   // Gain under tuning and its step size.
   always_comb begin
      case (index_ff)
         GAIN_P: begin
            dp = step_ff[0];
            gain_k = gain_ff[0];
         end
         GAIN_I: begin
            dp = step_ff[1];
            gain_k = gain_ff[1];
         end
         GAIN_D: begin
            dp = step_ff[2];
            gain_k = gain_ff[2];
         end
         default: begin
            dp = step_ff[0];
            gain_k = gain_ff[0];
         end
      endcase
   end

   always_comb begin
      step_total = {2'b00, step_ff[0]} + {2'b00, step_ff[1]} + {2'b00, step_ff[2]};
      step_others = step_total - {2'b00, dp};
      done_now = (step_total <= {3'b000, tolerance_ff});
      gain_plus = {{3{gain_k[GAIN_BITS-1]}}, gain_k} + {3'b000, dp};
      gain_minus = {{3{gain_k[GAIN_BITS-1]}}, gain_k} - {2'b00, dp, 1'b0};
      gain_plus_sat = sat_gain(gain_plus);
      gain_minus_sat = sat_gain(gain_minus);
      index_next = (index_ff == GAIN_D) ? GAIN_P : index_ff + 2'd1;
   end

   twd_step_scale u_step_scale (
      .clock(clock),
      .step_cur(dp),
      .step_others(step_others),
      .tolerance(tolerance_ff),
      .scale(scale)
   );

   // Per-sample update: count, accumulate, or (while tuning is not done) take one twiddle decision.
   always_comb begin
      count_in = count_ff;
      err_sum_in = err_sum_ff;
      best_in = best_ff;
      index_in = index_ff;
      tried_in = tried_ff;
      apply_in = apply_ff;
      first_in = first_ff;
      gain_wr = 1'b0;
      step_wr = 1'b0;
      gain_new = gain_plus_sat;
      step_new = scale.grow;
      done_next = done_now;
      if (in_settle) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (in_eval) begin
         err_sum_in = sum_next[SUM_BITS] ? '1 : sum_next[SUM_BITS-1:0];
         count_in = count_ff + COUNT_BITS'(1);
      end else if (!done_now) begin
         if (apply_ff) begin
            if (first_ff) begin
               best_in = err_sum_ff;
               first_in = 1'b0;
            end
            gain_wr = 1'b1;
            count_in = '0;
            err_sum_in = '0;
            apply_in = 1'b0;
         end else if (err_sum_ff < best_ff) begin
            best_in = err_sum_ff;
            step_wr = 1'b1;
            index_in = index_next;
            tried_in = 1'b0;
            apply_in = 1'b1;
            done_next = scale.grow_done;
         end else if (!tried_ff) begin
            gain_wr = 1'b1;
            gain_new = gain_minus_sat;
            count_in = '0;
            err_sum_in = '0;
            tried_in = 1'b1;
         end else begin
            gain_wr = 1'b1;
            step_wr = 1'b1;
            step_new = scale.shrink;
            index_in = index_next;
            tried_in = 1'b0;
            apply_in = 1'b1;
            done_next = scale.shrink_done;
         end
      end
      for (int i = 0; i < NUM_GAINS; i++) begin
         gain_in[i] = (gain_wr && index_ff == 2'(i)) ? gain_new : gain_ff[i];
         step_in[i] = (step_wr && index_ff == 2'(i)) ? step_new : step_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (restart) begin
         count_ff <= (CMP_BITS'(ld_settle) >= CMP_BITS'(CNT_MAX)) ?
                     CNT_MAX : COUNT_BITS'(ld_settle);
         err_sum_ff <= '0;
         best_ff <= '1;
         step_ff[0] <= {1'b0, ld_step_pd};
         step_ff[1] <= {1'b0, ld_step_i};
         step_ff[2] <= {1'b0, ld_step_pd};
         gain_ff[0] <= ld_kp;
         gain_ff[1] <= ld_ki;
         gain_ff[2] <= ld_kd;
         index_ff <= GAIN_P;
         tried_ff <= 1'b0;
         apply_ff <= 1'b1;
         first_ff <= 1'b1;
      end else if (accept) begin
         count_ff <= count_in;
         err_sum_ff <= err_sum_in;
         best_ff <= best_in;
         step_ff <= step_in;
         gain_ff <= gain_in;
         index_ff <= index_in;
         tried_ff <= tried_in;
         apply_ff <= apply_in;
         first_ff <= first_in;
      end
   end

   always_comb begin
      result.gain_p = gain_in[0];
      result.gain_i = gain_in[1];
      result.gain_d = gain_in[2];
      result.gain_index = index_in;
      result.tuning_done = done_next;
   end

   // Output register with one skid entry behind it.
   assign take = out_valid_ff && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_ff <= 1'b1;
            skid_valid_ff <= accept;
         end else begin
            out_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
            if (accept) begin
               skid_ff <= result;
            end
         end else if (accept) begin
            out_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.payload = out_ff;

endmodule
